[rtl/vertex_rotate_translate_bbox_assert.svh]
// Assertion macros shared by the checkers of this block.
// Each one samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef VERTEX_ROTATE_TRANSLATE_BBOX_ASSERT_SVH
`define VERTEX_ROTATE_TRANSLATE_BBOX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRTB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vrtb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VRTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vrtb: next-cycle check failed");

`endif

[rtl/vrtb_pkg.sv]
`default_nettype none

package vrtb_pkg;

  localparam int COORD_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Z = 3'd6;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  // Q1.14 unity, also the clamp for sine magnitudes
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

endpackage

`default_nettype wire

[rtl/vertex_rotate_translate_bbox.sv]
// Vertex transform with running bounding box.
// Input channel: one vertex beat (vx/vy/vz in signed Q8.8, is_center, last)
// per accepted handshake, in_valid_i high and in_stall_o low.
// Output channel: one result beat per input beat, in order: the transformed
// vertex R*(v - pivot) + target, saturated, plus the box min/max including
// this vertex (center vertices are kept out) and box_final = last.
// Pipeline: input register, multiply-accumulate register, box/output
// register. Throughput: one vertex per cycle while out_stall_i is low and
// no matrix rebuild is running.
// Writing the angles register rebuilds the rotation matrix on one shared
// multiplier: first the sine and cosine of each angle (6 values), then the
// 9 matrix entries; in_stall_o is held high until the rebuild ends.
// Pivot and target writes take effect at once.
// Reset: identity matrix, zero pivot/target, empty box, pipeline empty.
// When out_stall_i is high with out_valid_o high, the whole pipeline holds
// and in_stall_o rises in the same cycle; a held result beat keeps its payload.
`default_nettype none

module vertex_rotate_translate_bbox import vrtb_pkg::*; (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [CFG_W-1:0]            cfg_data_i,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  signed [COORD_W-1:0]   vx_i,
  input  wire  signed [COORD_W-1:0]   vy_i,
  input  wire  signed [COORD_W-1:0]   vz_i,
  input  wire                         is_center_i,
  input  wire                         last_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic signed [COORD_W-1:0]   ox_o,
  output logic signed [COORD_W-1:0]   oy_o,
  output logic signed [COORD_W-1:0]   oz_o,
  output logic signed [COORD_W-1:0]   min_x_o,
  output logic signed [COORD_W-1:0]   min_y_o,
  output logic signed [COORD_W-1:0]   min_z_o,
  output logic signed [COORD_W-1:0]   max_x_o,
  output logic signed [COORD_W-1:0]   max_y_o,
  output logic signed [COORD_W-1:0]   max_z_o,
  output logic                        box_final_o
);

  // matrix entries may slightly exceed unity after rounding
  localparam int MAT_W  = 17;
  localparam int DIFF_W = COORD_W + 1;
  localparam int MAC_W  = MAT_W + DIFF_W + 2;
  localparam int RSH_W  = MAC_W - 14;
  localparam int SUM_W  = RSH_W + 1;
  localparam int ACC_W  = 46;
  localparam int FRAC_SHIFT = 18 - ANGLE_W;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(1) << (ANGLE_W - 2);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SIN  = 2'd1;
  localparam logic [1:0] ST_MAT  = 2'd2;

  // operand codes: sine/cosine slots and the unity constant
  localparam logic [2:0] OP_SX  = 3'd0;
  localparam logic [2:0] OP_CX  = 3'd1;
  localparam logic [2:0] OP_SY  = 3'd2;
  localparam logic [2:0] OP_CY  = 3'd3;
  localparam logic [2:0] OP_SZ  = 3'd4;
  localparam logic [2:0] OP_CZ  = 3'd5;
  localparam logic [2:0] OP_ONE = 3'd6;

  typedef struct packed {
    logic [2:0] ia;
    logic [2:0] ib;
    logic [2:0] ic;
    logic [2:0] id;
    logic [2:0] ie;
    logic       neg_ab;
    logic       neg_cde;
    logic       has_cde;
  } mat_sel_t;

  // Entry k = ±A*B*2^14 ± C*D*E, with R = Rx*Ry*Rz.
  function automatic mat_sel_t mat_sel(input logic [3:0] k);
    mat_sel_t s;
    s = '{ia: OP_ONE, ib: OP_ONE, ic: OP_ONE, id: OP_ONE, ie: OP_ONE,
          neg_ab: 1'b0, neg_cde: 1'b0, has_cde: 1'b0};
    unique case (k)
      4'd0: begin s.ia = OP_CY; s.ib = OP_CZ; end
      4'd1: begin s.ia = OP_CY; s.ib = OP_SZ; s.neg_ab = 1'b1; end
      4'd2: begin s.ia = OP_SY; s.ib = OP_ONE; end
      4'd3: begin
        s.ia = OP_CX; s.ib = OP_SZ;
        s.ic = OP_SX; s.id = OP_SY; s.ie = OP_CZ; s.has_cde = 1'b1;
      end
      4'd4: begin
        s.ia = OP_CX; s.ib = OP_CZ;
        s.ic = OP_SX; s.id = OP_SY; s.ie = OP_SZ; s.has_cde = 1'b1; s.neg_cde = 1'b1;
      end
      4'd5: begin s.ia = OP_SX; s.ib = OP_CY; s.neg_ab = 1'b1; end
      4'd6: begin
        s.ia = OP_SX; s.ib = OP_SZ;
        s.ic = OP_CX; s.id = OP_SY; s.ie = OP_CZ; s.has_cde = 1'b1; s.neg_cde = 1'b1;
      end
      4'd7: begin
        s.ia = OP_SX; s.ib = OP_CZ;
        s.ic = OP_CX; s.id = OP_SY; s.ie = OP_SZ; s.has_cde = 1'b1;
      end
      4'd8: begin s.ia = OP_CX; s.ib = OP_CY; end
      default: ;
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]          angles_q;
  logic signed [COORD_W-1:0] pivot_q  [3];
  logic signed [COORD_W-1:0] target_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angles_q <= '0;
      for (int j = 0; j < 3; j++) begin
        pivot_q[j]  <= '0;
        target_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANGLES:   angles_q    <= cfg_data_i;
        CFG_PIVOT_X:  pivot_q[0]  <= cfg_data_i[COORD_W-1:0];
        CFG_PIVOT_Y:  pivot_q[1]  <= cfg_data_i[COORD_W-1:0];
        CFG_PIVOT_Z:  pivot_q[2]  <= cfg_data_i[COORD_W-1:0];
        CFG_TARGET_X: target_q[0] <= cfg_data_i[COORD_W-1:0];
        CFG_TARGET_Y: target_q[1] <= cfg_data_i[COORD_W-1:0];
        CFG_TARGET_Z: target_q[2] <= cfg_data_i[COORD_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Matrix rebuild sequencer on one shared multiplier
  // ---------------------------------------------------------------------
  logic [1:0]  st_q, st_d;
  logic [3:0]  k_q, k_d;
  logic [2:0]  step_q, step_d;
  logic [16:0] x_q, x_d;
  logic [16:0] x2_q, x2_d;
  logic signed [15:0] hold_q, hold_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [50:0] prod_q, prod_d;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;

  logic signed [15:0]      sc_q  [6];
  logic signed [MAT_W-1:0] rot_q [9];
  logic                    sc_we, rot_we;
  logic signed [15:0]      sc_wdata;
  logic signed [MAT_W-1:0] rot_wdata;

  // sine argument for slot k: axis k/2, cosine on odd k
  logic [ANGLE_W-1:0] ang_raw, ang;
  logic [1:0]         quad;
  logic [16:0]        x_raw, x_fold;
  logic [16:0]        prod_hi;
  logic [17:0]        s_rnd;
  logic [15:0]        s_mag;

  always_comb begin
    unique case (k_q[2:1])
      2'd1:    ang_raw = angles_q[2*ANGLE_W-1:ANGLE_W];
      2'd2:    ang_raw = angles_q[3*ANGLE_W-1:2*ANGLE_W];
      default: ang_raw = angles_q[ANGLE_W-1:0];
    endcase
    ang    = ang_raw + (k_q[0] ? QUARTER_TURN : '0);
    quad   = ang[ANGLE_W-1:ANGLE_W-2];
    x_raw  = 17'(ang[ANGLE_W-3:0]) << FRAC_SHIFT;
    x_fold = quad[0] ? (17'd65536 - x_raw) : x_raw;
    prod_hi = prod_q[32:16];
    s_rnd  = {1'b0, prod_hi} + 18'd2;
    s_mag  = (s_rnd[17:2] > 16'(ONE_Q14)) ? 16'(ONE_Q14) : s_rnd[17:2];
  end

  mat_sel_t           msel;
  logic [2:0]         op_idx;
  logic signed [15:0] op_val;
  logic signed [ACC_W-1:0] p_ab, p_cde, acc_fin, acc_rnd;

  always_comb begin
    msel = mat_sel(k_q);
    unique case (step_q)
      3'd1:    op_idx = msel.ib;
      3'd2:    op_idx = msel.ic;
      3'd3:    op_idx = msel.id;
      3'd4:    op_idx = msel.ie;
      default: op_idx = msel.ia;
    endcase
    op_val = (op_idx < OP_ONE) ? sc_q[op_idx] : ONE_Q14;
    p_ab    = $signed(prod_q[ACC_W-1:0]) <<< 14;
    p_cde   = $signed(prod_q[ACC_W-1:0]);
    acc_fin = !msel.has_cde ? acc_q :
              (msel.neg_cde ? (acc_q - p_cde) : (acc_q + p_cde));
    acc_rnd = acc_fin + (ACC_W'(1) <<< 27);
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    st_d = st_q;  k_d = k_q;  step_d = step_q;
    x_d = x_q;  x2_d = x2_q;  hold_d = hold_q;  acc_d = acc_q;
    mul_a = '0;  mul_b = '0;
    sc_we = 1'b0;  sc_wdata = quad[1] ? -$signed(s_mag) : $signed(s_mag);
    rot_we = 1'b0; rot_wdata = acc_rnd[MAT_W+27:28];
    unique case (st_q)
      ST_SIN: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: begin
            x_d   = x_fold;
            mul_a = $signed({16'd0, x_fold});
            mul_b = $signed({1'b0, x_fold});
          end
          3'd1: begin
            x2_d  = prod_hi;
            mul_a = $signed({16'd0, prod_hi});
            mul_b = 18'sd4640;
          end
          3'd2: begin
            mul_a = $signed({16'd0, x2_q});
            mul_b = $signed({1'b0, 17'd42048 - prod_hi});
          end
          3'd3: begin
            mul_a = $signed({16'd0, x_q});
            mul_b = $signed({1'b0, 17'd102944 - prod_hi});
          end
          default: begin
            sc_we  = 1'b1;
            step_d = 3'd0;
            if (k_q == 4'd5) begin
              st_d = ST_MAT;
              k_d  = 4'd0;
            end else begin
              k_d = k_q + 4'd1;
            end
          end
        endcase
      end
      ST_MAT: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: hold_d = op_val;
          3'd1: begin
            mul_a = 33'(hold_q);
            mul_b = 18'(op_val);
          end
          3'd2: begin
            acc_d  = msel.neg_ab ? -p_ab : p_ab;
            hold_d = op_val;
          end
          3'd3: begin
            mul_a = 33'(hold_q);
            mul_b = 18'(op_val);
          end
          3'd4: begin
            mul_a = $signed(prod_q[32:0]);
            mul_b = 18'(op_val);
          end
          default: begin
            rot_we = 1'b1;
            step_d = 3'd0;
            if (k_q == 4'd8) begin
              st_d = ST_IDLE;
              k_d  = 4'd0;
            end else begin
              k_d = k_q + 4'd1;
            end
          end
        endcase
      end
      default: ;
    endcase
    // a new angle set restarts the rebuild from the first sine
    if (cfg_we_i && cfg_idx_i == CFG_ANGLES) begin
      st_d = ST_SIN;  k_d = 4'd0;  step_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      k_q    <= '0;
      step_q <= '0;
      for (int i = 0; i < 9; i++) begin
        rot_q[i] <= (i == 0 || i == 4 || i == 8) ? MAT_W'(ONE_Q14) : '0;
      end
    end else begin
      st_q   <= st_d;
      k_q    <= k_d;
      step_q <= step_d;
      if (rot_we) rot_q[k_q] <= rot_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    x2_q   <= x2_d;
    hold_q <= hold_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    if (sc_we) sc_q[k_q[2:0]] <= sc_wdata;
  end

  // ---------------------------------------------------------------------
  // Vertex pipeline: input register, multiply-accumulate, box/output
  // ---------------------------------------------------------------------
  logic adv;
  logic busy;

  assign busy       = (st_q != ST_IDLE);
  assign adv        = !out_valid_o || !out_stall_i;  // advance unless result held
  assign in_stall_o = busy || !adv;

  logic                     a_vld_q, a_ctr_q, a_last_q;
  logic signed [DIFF_W-1:0] a_d_q [3];
  logic signed [COORD_W-1:0] v_in [3];

  assign v_in[0] = vx_i;
  assign v_in[1] = vy_i;
  assign v_in[2] = vz_i;

  logic                      b_vld_q, b_ctr_q, b_last_q;
  logic signed [COORD_W-1:0] b_r_q [3];
  logic signed [COORD_W-1:0] r_d   [3];
  logic signed [MAC_W-1:0]   mac   [3];
  logic signed [MAC_W-1:0]   mac_r [3];
  logic signed [SUM_W-1:0]   sum   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mac[i] = '0;
      for (int j = 0; j < 3; j++) begin
        mac[i] = mac[i] + MAC_W'(rot_q[3*i+j] * a_d_q[j]);
      end
      mac_r[i] = mac[i] + (MAC_W'(1) <<< 13);
      sum[i]   = SUM_W'($signed(mac_r[i][MAC_W-1:14])) + SUM_W'(target_q[i]);
      if (sum[i] > SUM_W'(COORD_MAX)) begin
        r_d[i] = COORD_MAX;
      end else if (sum[i] < SUM_W'(COORD_MIN)) begin
        r_d[i] = COORD_MIN;
      end else begin
        r_d[i] = sum[i][COORD_W-1:0];
      end
    end
  end

  // box update for the beat leaving stage B
  logic signed [COORD_W-1:0] box_lo_q [3];
  logic signed [COORD_W-1:0] box_hi_q [3];
  logic signed [COORD_W-1:0] lo_d [3];
  logic signed [COORD_W-1:0] hi_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_d[i] = box_lo_q[i];
      hi_d[i] = box_hi_q[i];
      if (!b_ctr_q) begin
        if (b_r_q[i] < box_lo_q[i]) lo_d[i] = b_r_q[i];
        if (b_r_q[i] > box_hi_q[i]) hi_d[i] = b_r_q[i];
      end
    end
  end

  logic signed [COORD_W-1:0] o_r_q  [3];
  logic signed [COORD_W-1:0] o_lo_q [3];
  logic signed [COORD_W-1:0] o_hi_q [3];
  logic                      o_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        box_lo_q[i] <= COORD_MAX;
        box_hi_q[i] <= COORD_MIN;
      end
    end else if (adv) begin
      a_vld_q     <= in_valid_i && !busy;
      b_vld_q     <= a_vld_q;
      out_valid_o <= b_vld_q;
      if (b_vld_q) begin
        for (int i = 0; i < 3; i++) begin
          // close the shape: clear the box after reporting it
          box_lo_q[i] <= b_last_q ? COORD_MAX : lo_d[i];
          box_hi_q[i] <= b_last_q ? COORD_MIN : hi_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ctr_q  <= is_center_i;
      a_last_q <= last_i;
      b_ctr_q  <= a_ctr_q;
      b_last_q <= a_last_q;
      o_final_q <= b_last_q;
      for (int i = 0; i < 3; i++) begin
        a_d_q[i]  <= DIFF_W'(v_in[i]) - DIFF_W'(pivot_q[i]);
        b_r_q[i]  <= r_d[i];
        o_r_q[i]  <= b_r_q[i];
        o_lo_q[i] <= lo_d[i];
        o_hi_q[i] <= hi_d[i];
      end
    end
  end

  assign ox_o        = o_r_q[0];
  assign oy_o        = o_r_q[1];
  assign oz_o        = o_r_q[2];
  assign min_x_o     = o_lo_q[0];
  assign min_y_o     = o_lo_q[1];
  assign min_z_o     = o_lo_q[2];
  assign max_x_o     = o_hi_q[0];
  assign max_y_o     = o_hi_q[1];
  assign max_z_o     = o_hi_q[2];
  assign box_final_o = o_final_q;

endmodule

`default_nettype wire

[rtl/vrtb_checker.sv]
`default_nettype none

`include "vertex_rotate_translate_bbox_assert.svh"

module vrtb_props import vrtb_pkg::*; (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       cfg_we_i,
  input wire [CFG_IDX_W-1:0]       cfg_idx_i,
  input wire                       in_stall_o,
  input wire                       out_valid_o,
  input wire                       out_stall_i,
  input wire signed [COORD_W-1:0]  ox_o,
  input wire signed [COORD_W-1:0]  min_x_o,
  input wire signed [COORD_W-1:0]  max_x_o,
  input wire                       box_final_o
);

  logic out_held;
  logic box_ok;

  assign out_held = out_valid_o && out_stall_i;
  assign box_ok   = (min_x_o <= max_x_o) || (min_x_o == COORD_MAX && max_x_o == COORD_MIN);

  // held result beat stays valid and unchanged
  `VRTB_ASSERT_NEXT(a_out_hold, out_held, out_valid_o)
  `VRTB_ASSERT_NEXT(a_out_stable, out_held, $stable({ox_o, min_x_o, max_x_o, box_final_o}))
  // x extent of the box is either empty or ordered
  `VRTB_ASSERT_NOW(a_box_order, out_valid_o, box_ok)
  // a new angle set blocks input while the matrix is rebuilt
  `VRTB_ASSERT_NEXT(a_rebuild_stall, cfg_we_i && cfg_idx_i == CFG_ANGLES, in_stall_o)

endmodule

bind vertex_rotate_translate_bbox vrtb_props u_vrtb_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ox_o        (ox_o),
  .min_x_o     (min_x_o),
  .max_x_o     (max_x_o),
  .box_final_o (box_final_o)
);

`default_nettype wire
